[rtl/core/btpf_pkg.sv]
// Package for the binary trie prefix filter: beat types, status and request codes,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package btpf_pkg;

  localparam int ADDR_BITS     = 32;
  localparam int MAX_NODES_DEF = 16384;
  localparam int LEN_W         = 6;
  localparam int STATUS_W      = 2;
  localparam int LVL_W         = $clog2(ADDR_BITS + 1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic                 req_type;
    logic [ADDR_BITS-1:0] address;
    logic [LEN_W-1:0]     prefix_len;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    match_len;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;
    logic                step;
    logic                alloc;
    logic                mark;
    logic                clear;
    logic                finish;
    logic [STATUS_W-1:0] fin_status;
    logic                fin_hit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic lookup;
    logic at_end;
    logic hit;
    logic child_nz;
    logic full;
    logic fresh;
    logic is_root;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/btpf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module btpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/btpf_ctrl.sv]
// Walk controller for the binary trie prefix filter.
// Depends on btpf_pkg for the command and status structs and codes.
`timescale 1ns / 1ps

module btpf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          busy,
  input  btpf_pkg::sts_t sts,
  output btpf_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.lookup) begin
          if (sts.hit) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = btpf_pkg::ST_HIT;
            cmd.fin_hit    = 1'b1;
          end else if (sts.at_end || !sts.child_nz) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = btpf_pkg::ST_MISS;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          if (sts.at_end) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = btpf_pkg::ST_INSERTED;
            cmd.mark       = !sts.is_root;
          end else if (sts.child_nz) begin
            cmd.step = 1'b1;
          end else if (sts.full) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = btpf_pkg::ST_FULL;
            cmd.clear      = sts.fresh;
          end else begin
            cmd.alloc = 1'b1;
          end
        end
        // A finishing step, with its final write, waits until the result register is free.
        if (cmd.finish) begin
          if (sts.out_free) begin
            state_nxt = S_IDLE;
          end else begin
            cmd = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == S_WALK);

endmodule

[rtl/core/btpf_dp.sv]
// Datapath of the binary trie prefix filter: walk registers, root links, free pointer,
// node memory and result register. Depends on btpf_pkg and btpf_ram.
`timescale 1ns / 1ps

module btpf_dp #(
  parameter int MAX_NODES = btpf_pkg::MAX_NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  btpf_pkg::in_beat_t  in_data,
  input  btpf_pkg::cmd_t      cmd,
  output btpf_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_stall,
  output btpf_pkg::out_beat_t out_data
);

  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = 2 * NW + 1;
  localparam int AB = btpf_pkg::ADDR_BITS;
  localparam int LW = btpf_pkg::LVL_W;

  logic          type_r;
  logic [AB-1:0] addr_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] level_r;
  logic [NW-1:0] node_r;
  logic          fresh_r;
  logic [NW:0]   nfn_r;
  logic [NW-1:0] root0_r, root1_r;
  logic          out_valid_r;
  btpf_pkg::out_beat_t out_r;

  logic [EW-1:0] rd_data;
  logic [EW-1:0] wr_data;
  logic          wr_en;
  logic [NW-1:0] cur_l0, cur_l1, child, new_idx;
  logic          cur_mark, dir_bit, is_root;
  logic [LW-1:0] len_clamped;

  assign is_root = (node_r == '0);
  assign dir_bit = addr_r[AB-1];
  assign new_idx = nfn_r[NW-1:0];

  // The root lives in registers; a node just allocated on this walk has no entry yet.
  always_comb begin
    if (is_root) begin
      cur_mark = 1'b0;
      cur_l0   = root0_r;
      cur_l1   = root1_r;
    end else if (fresh_r) begin
      cur_mark = 1'b0;
      cur_l0   = '0;
      cur_l1   = '0;
    end else begin
      cur_mark = rd_data[2*NW];
      cur_l1   = rd_data[2*NW-1:NW];
      cur_l0   = rd_data[NW-1:0];
    end
  end

  assign child = dir_bit ? cur_l1 : cur_l0;

  always_comb begin
    if (cmd.mark) begin
      wr_data = {1'b1, cur_l1, cur_l0};
    end else if (cmd.alloc) begin
      wr_data = dir_bit ? {cur_mark, new_idx, cur_l0} : {cur_mark, cur_l1, new_idx};
    end else begin
      wr_data = '0;
    end
  end

  assign wr_en = (cmd.alloc && !is_root) || cmd.mark || cmd.clear;

  btpf_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (node_r),
    .wr_data (wr_data),
    .rd_en   (cmd.step),
    .rd_addr (child),
    .rd_data (rd_data)
  );

  assign len_clamped = (in_data.prefix_len > btpf_pkg::LEN_W'(AB)) ?
                       LW'(AB) : LW'(in_data.prefix_len);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r  <= in_data.req_type;
      addr_r  <= in_data.address;
      len_r   <= len_clamped;
      level_r <= '0;
      node_r  <= '0;
      fresh_r <= 1'b0;
    end else if (cmd.step || cmd.alloc) begin
      addr_r  <= {addr_r[AB-2:0], 1'b0};
      level_r <= level_r + LW'(1);
      node_r  <= cmd.step ? child : new_idx;
      fresh_r <= cmd.alloc;
    end
    if (cmd.finish) begin
      out_r.status    <= cmd.fin_status;
      out_r.match_len <= cmd.fin_hit ? btpf_pkg::LEN_W'(level_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfn_r       <= (NW + 1)'(1);
      root0_r     <= '0;
      root1_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        nfn_r <= nfn_r + (NW + 1)'(1);
        if (is_root) begin
          if (dir_bit) begin
            root1_r <= new_idx;
          end else begin
            root0_r <= new_idx;
          end
        end
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.lookup   = (type_r == btpf_pkg::REQ_LOOKUP);
  assign sts.at_end   = (level_r == len_r);
  assign sts.hit      = !is_root && cur_mark;
  assign sts.child_nz = (child != '0);
  assign sts.full     = (nfn_r == (NW + 1)'(MAX_NODES));
  assign sts.fresh    = fresh_r;
  assign sts.is_root  = is_root;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/binary_trie_prefix_filter_unit.sv]
// Top level of the binary trie prefix filter: walk controller, datapath and node memory.
// Depends on btpf_pkg, btpf_ctrl, btpf_dp and btpf_ram.
`timescale 1ns / 1ps

// Usage
// The block stores address prefixes in a binary trie and answers shortest-prefix lookups.
// Input channel (in_valid, in_stall, in_data): a beat carries req_type (insert or lookup),
// a 32-bit address taken most significant bit first, and prefix_len, clamped to 32.
// Output channel (out_valid, out_stall, out_data): every input beat yields exactly one
// result beat with status (inserted, hit, miss, store full) and match_len.
// Timing: an item holds the block while it walks its trie levels (0 to 32) and takes its
// finishing step, and its result is registered at the edge that ends the walk.
// The next item can be accepted once the block is back in idle. The walk's pace is set
// by the node memory, which serves one read or one write per level.
// One item is in flight at a time: in_stall is high from the accepting edge until its
// result has been loaded into the output register.
// A finished result sits in the output register while the next item is accepted and walked.
// If the receiver stalls and the register still holds a beat, the walk waits at its final
// step, with the final node write held back, until the register frees.
// Reset clears the root links, sets the free-node pointer to 1 and empties the output.
// The node memory needs no clearing pass: a new node is written before its walk ends.
module binary_trie_prefix_filter_unit #(
  parameter int MAX_NODES = btpf_pkg::MAX_NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  btpf_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output btpf_pkg::out_beat_t out_data
);

  btpf_pkg::cmd_t cmd;
  btpf_pkg::sts_t sts;
  logic           busy;

  // The controller sequences the walk, one trie level per cycle.
  btpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .busy     (busy),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the walk state, the root node, the node memory and the result.
  btpf_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Busy while an item is being walked.
  assign in_stall = busy;

endmodule

[rtl/core/btpf_checker.sv]
// Port-level checker for the binary trie prefix filter, bound to the top level.
// Depends on btpf_pkg and binary_trie_prefix_filter_unit.
`timescale 1ns / 1ps

module btpf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input btpf_pkg::out_beat_t out_data
);

  // An accepted item keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Only a hit carries a match length.
  a_len_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != btpf_pkg::ST_HIT) |-> out_data.match_len == '0)
    else $error("match length on a result that is not a hit");

  // A hit always lies at a depth between one and the address width.
  a_hit_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == btpf_pkg::ST_HIT) |->
      (out_data.match_len != '0) &&
      (out_data.match_len <= btpf_pkg::LEN_W'(btpf_pkg::ADDR_BITS)))
    else $error("hit depth out of range");

endmodule

bind binary_trie_prefix_filter_unit btpf_checker u_btpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[dv/binary_trie_prefix_filter_unit_tb.sv]
// Self-checking testbench for binary_trie_prefix_filter_unit: a trie predictor,
// random stimulus, random stalls and a per-field comparison of the result beats.
// Depends on btpf_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module binary_trie_prefix_filter_unit_tb;

  localparam int NODE_CAP    = btpf_pkg::MAX_NODES_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_TAIL  = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  btpf_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  btpf_pkg::out_beat_t out_data;

  // The predictor keeps its own copy of the trie. A child index of zero means
  // that there is no child, since the root is never anybody's child.
  int unsigned trie_kid [NODE_CAP][2];
  bit          trie_mark [NODE_CAP];
  logic [5:0]  trie_depth [NODE_CAP];
  int unsigned trie_next;

  btpf_pkg::out_beat_t pending_results [$];
  logic [31:0]         stored_addr [$];
  logic [5:0]          stored_len [$];
  bit                  store_full_seen = 1'b0;
  bit                  quiet_src = 1'b1;
  bit                  quiet_sink = 1'b1;
  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  int                  sink_hold = 0;

  binary_trie_prefix_filter_unit #(
    .MAX_NODES(NODE_CAP)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Most idle gaps are short; now and then a long one, so that pauses land on
  // every phase of a walk, including the wait for a full output register.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Walks the predictor's trie exactly as the unit should: inserts allocate
  // missing nodes in order and mark the last one, lookups stop at the first
  // marked node, which is the shortest stored prefix that matches.
  function automatic btpf_pkg::out_beat_t trie_predict(btpf_pkg::in_beat_t beat);
    btpf_pkg::out_beat_t res;
    int unsigned         node;
    int unsigned         kid;
    int unsigned         walk;
    int                  lvl;
    logic                dir;
    res.status    = (beat.req_type == btpf_pkg::REQ_INSERT) ?
                    btpf_pkg::ST_INSERTED : btpf_pkg::ST_MISS;
    res.match_len = '0;
    node = 0;
    walk = (beat.prefix_len > btpf_pkg::ADDR_BITS) ? btpf_pkg::ADDR_BITS : beat.prefix_len;
    for (lvl = 0; lvl < walk; lvl++) begin
      dir = beat.address[btpf_pkg::ADDR_BITS-1-lvl];
      kid = trie_kid[node][dir];
      if (beat.req_type == btpf_pkg::REQ_INSERT) begin
        if (kid == 0) begin
          // Out of nodes: the path built so far stays behind, unmarked.
          if (trie_next >= NODE_CAP) begin
            res.status = btpf_pkg::ST_FULL;
            return res;
          end
          kid = trie_next;
          trie_next++;
          trie_kid[kid][0]   = 0;
          trie_kid[kid][1]   = 0;
          trie_mark[kid]     = 1'b0;
          trie_depth[kid]    = 6'(lvl + 1);
          trie_kid[node][dir] = kid;
        end
      end else begin
        if (kid == 0) return res;
        if (trie_mark[kid]) begin
          res.status    = btpf_pkg::ST_HIT;
          res.match_len = trie_depth[kid];
          return res;
        end
      end
      node = kid;
    end
    // A zero-length insert walks nothing and leaves the root unmarked.
    if (beat.req_type == btpf_pkg::REQ_INSERT && walk > 0) trie_mark[node] = 1'b1;
    return res;
  endfunction

  // An address that falls under the given prefix, with random bits below it.
  function automatic logic [31:0] under_prefix(logic [31:0] pfx, logic [5:0] len);
    logic [31:0] keep;
    int          bits;
    bits = (len > btpf_pkg::ADDR_BITS) ? btpf_pkg::ADDR_BITS : len;
    keep = (bits == 0) ? 32'h0 : (~32'h0 << (btpf_pkg::ADDR_BITS - bits));
    return (pfx & keep) | ($urandom() & ~keep);
  endfunction

  // Offers one beat, waits for the handshake and records the expected result.
  // Valid stays high into the next call when that call has no gap, so it is
  // never lowered and raised in the same time step.
  task automatic send_beat(input logic req, input logic [31:0] addr, input logic [5:0] len);
    btpf_pkg::in_beat_t  beat;
    btpf_pkg::out_beat_t want;
    int                  gap;
    beat.req_type   = req;
    beat.address    = addr;
    beat.prefix_len = len;
    gap = quiet_src ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    want = trie_predict(beat);
    if (want.status == btpf_pkg::ST_FULL) store_full_seen = 1'b1;
    if (req == btpf_pkg::REQ_INSERT) begin
      stored_addr = {stored_addr, addr};
      stored_len  = {stored_len, len};
    end
    pending_results = {pending_results, want};
  endtask

  // Holds the input idle until every expected result beat has come back.
  // At least one edge passes, so valid is never driven twice in one time step.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // A lookup that usually lands under a prefix already sent, so that hits,
  // shallow matches and dead ends on partial paths all turn up often.
  task automatic send_lookup_near_stored(input logic [5:0] len);
    int pick;
    if (stored_addr.size() == 0) begin
      send_beat(btpf_pkg::REQ_LOOKUP, $urandom(), len);
    end else begin
      pick = $urandom_range(0, stored_addr.size() - 1);
      send_beat(btpf_pkg::REQ_LOOKUP, under_prefix(stored_addr[pick], stored_len[pick]), len);
    end
  endtask

  task automatic test_empty_trie();
    send_beat(btpf_pkg::REQ_LOOKUP, 32'hA5A5_A5A5, 6'd32);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd0);
    // A zero-length insert reports success but must not mark the root.
    send_beat(btpf_pkg::REQ_INSERT, 32'hDEAD_BEEF, 6'd0);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'hDEAD_BEEF, 6'd32);
    drain_results();
  endtask

  task automatic test_directed_prefixes();
    // A length above 32 is clamped to the full address.
    send_beat(btpf_pkg::REQ_INSERT, 32'hFFFF_FFFF, 6'd63);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 6'd32);
    send_beat(btpf_pkg::REQ_INSERT, 32'h0000_0000, 6'd32);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd40);
    // The walk ends before the marked node is reached.
    send_beat(btpf_pkg::REQ_LOOKUP, 32'h0000_0000, 6'd16);
    // Missing child on the second level.
    send_beat(btpf_pkg::REQ_LOOKUP, 32'h7FFF_FFFF, 6'd32);
    send_beat(btpf_pkg::REQ_INSERT, 32'h8000_0000, 6'd1);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'hC000_0000, 6'd32);
    // Marking an already marked node again is harmless.
    send_beat(btpf_pkg::REQ_INSERT, 32'h8000_0000, 6'd1);
    send_beat(btpf_pkg::REQ_INSERT, 32'hC000_0000, 6'd2);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'hC000_0000, 6'd32);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 6'd32);
    send_beat(btpf_pkg::REQ_INSERT, 32'h1234_5678, 6'd24);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'h1234_56AB, 6'd32);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'h1234_56AB, 6'd23);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'h1234_5678, 6'd0);
    send_beat(btpf_pkg::REQ_LOOKUP, 32'h1234_5678, 6'd33);
    drain_results();
  endtask

  // Mixed inserts and lookups with idling on both sides. Quiet stretches and
  // full drains are sprinkled in at random.
  task automatic test_random_mix(input int count);
    int idx;
    int roll;
    logic [5:0] len;
    for (idx = 0; idx < count; idx++) begin
      if (idx % 150 == 0) begin
        quiet_src  = ($urandom_range(0, 3) == 0);
        quiet_sink = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 59) == 0) drain_results();
      roll = $urandom_range(0, 99);
      if (roll < 10) len = 6'($urandom_range(0, 63));
      else if (roll < 20) len = 6'($urandom_range(1, 7));
      else len = 6'($urandom_range(8, 32));
      roll = $urandom_range(0, 99);
      if (roll < 35) send_beat(btpf_pkg::REQ_INSERT, $urandom(), len);
      else if (roll < 80) send_lookup_near_stored($urandom_range(0, 4) == 0 ? len : 6'd32);
      else send_beat(btpf_pkg::REQ_LOOKUP, $urandom(), len);
    end
    drain_results();
  endtask

  // Fills the node store with long prefixes (24 to 63, clamped to 32) until an insert runs out
  // of nodes, then carries on for a while past that point.
  task automatic test_fill_store();
    int idx;
    int tail;
    quiet_src  = 1'b0;
    quiet_sink = 1'b0;
    tail = 0;
    for (idx = 0; idx < 2500 && tail < 20; idx++) begin
      if ($urandom_range(0, 4) == 0) send_lookup_near_stored(6'd32);
      else send_beat(btpf_pkg::REQ_INSERT, $urandom(), 6'($urandom_range(24, 63)));
      if (store_full_seen) tail++;
    end
    drain_results();
  endtask

  // With the store exhausted: prefixes whose path already exists still go in,
  // new ones fail, and lookups along the abandoned partial paths miss.
  task automatic test_full_store();
    int idx;
    int pick;
    for (idx = 0; idx < 60; idx++) begin
      pick = $urandom_range(0, stored_addr.size() - 1);
      case ($urandom_range(0, 3))
        0: begin
          send_beat(btpf_pkg::REQ_INSERT, stored_addr[pick], stored_len[pick]);
        end
        1: begin
          send_beat(btpf_pkg::REQ_INSERT, $urandom(), 6'($urandom_range(0, 63)));
        end
        default: begin
          send_lookup_near_stored(6'($urandom_range(0, 63)));
        end
      endcase
    end
    drain_results();
  endtask

  // The sink stalls in runs of random length, mostly short.
  always @(posedge clk) begin
    if (!rst_n || quiet_sink) begin
      out_stall <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      sink_hold <= pick_gap();
    end
  end

  // Every accepted result beat is matched against the oldest expectation.
  always @(posedge clk) begin
    btpf_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d match_len %0d",
                 $time, out_data.status, out_data.match_len);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.match_len !== want.match_len) begin
          $display("%0t: match_len mismatch: expected %0d, got %0d",
                   $time, want.match_len, out_data.match_len);
          mismatch_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    trie_kid[0][0] = 0;
    trie_kid[0][1] = 0;
    trie_mark[0]   = 1'b0;
    trie_depth[0]  = '0;
    trie_next      = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_trie();
    test_directed_prefixes();
    test_random_mix(950);
    test_fill_store();
    test_full_store();
    in_valid <= 1'b0;
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
